// ----- hdl/rcs_pkg.sv -----
// ----------------------------------------------------------------------------
// rcs_pkg
// shared types and codes of the range coverage set
// ----------------------------------------------------------------------------
package rcs_pkg;

    localparam int CMD_W   = 2;
    localparam int START_W = 12;
    localparam int END_W   = 13;
    localparam int PT_W    = 14;

    typedef logic [CMD_W-1:0]   t_cmd;
    typedef logic [START_W-1:0] t_start;
    typedef logic [END_W-1:0]   t_end;
    typedef logic [PT_W-1:0]    t_pt;

    localparam t_cmd CMD_ADD    = 2'd0;
    localparam t_cmd CMD_REMOVE = 2'd1;
    localparam t_cmd CMD_QUERY  = 2'd2;
    localparam t_cmd CMD_NONE   = 2'd3;

    typedef struct packed {
        t_cmd   cmd;
        t_start range_start;
        t_end   range_end;
    } t_item;

    typedef struct packed {
        logic covered;
        logic range_error;
    } t_res;

endpackage

// ----- hdl/rcs_in_if.sv -----
// ----------------------------------------------------------------------------
// rcs_in_if
// command channel: operation and half-open range
// ----------------------------------------------------------------------------
interface rcs_in_if;
    import rcs_pkg::*;

    logic   valid;
    logic   ready;
    t_cmd   cmd;
    t_start range_start;
    t_end   range_end;

    modport source (output valid, output cmd, output range_start, output range_end,
                    input ready);
    modport sink   (input valid, input cmd, input range_start, input range_end,
                    output ready);
endinterface

// ----- hdl/rcs_out_if.sv -----
// ----------------------------------------------------------------------------
// rcs_out_if
// result channel: query answer and range error flag
// ----------------------------------------------------------------------------
interface rcs_out_if;
    logic valid;
    logic ready;
    logic covered;
    logic range_error;

    modport source (output valid, output covered, output range_error, input ready);
    modport sink   (input valid, input covered, input range_error, output ready);
endinterface

// ----- hdl/range_coverage_set.sv -----
// ----------------------------------------------------------------------------
// range_coverage_set
// covered-point set over a bounded domain, kept as a bitmap in memory
// ----------------------------------------------------------------------------
// usage:
//   i_in carries cmd (add, remove, query) and a half-open range
//   [range_start, range_end); o_out returns one word per command with the
//   query answer and the empty-range error flag.
//   commands are handled one at a time; each add, remove or query with a
//   non-empty range walks bitmap words from word 0 up to the word holding the
//   last point before the clamped end, one word a cycle through the bitmap
//   memory with registered read data; an empty range or unknown command
//   skips the walk.
//   after reset a clearing pass zeroes the bitmap with i_in.ready low.
//   o_out is a register: the next command is taken while a result waits;
//   a finished result holds the walker until the output register frees.
// ----------------------------------------------------------------------------
module range_coverage_set #(
    parameter int DOMAIN_POINTS = 4096,
    parameter int WORD_BITS     = 64
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    rcs_in_if.sink  i_in,
    rcs_out_if.source o_out
);
    import rcs_pkg::*;

    localparam int NUM_WORDS = (DOMAIN_POINTS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

    t_item                item;
    t_res                 res;
    logic                 idle;
    logic                 res_valid;
    logic                 res_take;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic [WORD_BITS-1:0] rd_data;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [WORD_BITS-1:0] wr_data;

    logic r_o_valid;
    t_res r_o_res;

    assign item.cmd         = i_in.cmd;
    assign item.range_start = i_in.range_start;
    assign item.range_end   = i_in.range_end;
    assign i_in.ready       = idle;

    assign res_take = res_valid && (!r_o_valid || o_out.ready);

    rcs_seq #(
        .DOMAIN_POINTS (DOMAIN_POINTS),
        .WORD_BITS     (WORD_BITS),
        .NUM_WORDS     (NUM_WORDS),
        .AW            (AW)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_in.valid),
        .i_item      (item),
        .o_idle      (idle),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_take  (res_take),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data)
    );

    rcs_mem #(
        .DEPTH (NUM_WORDS),
        .AW    (AW),
        .DW    (WORD_BITS)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (res_take) begin
            r_o_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_o_res <= res;
        end
    end

    assign o_out.valid       = r_o_valid;
    assign o_out.covered     = r_o_res.covered;
    assign o_out.range_error = r_o_res.range_error;
endmodule

// ----- hdl/rcs_mem.sv -----
// ----------------------------------------------------------------------------
// rcs_mem
// coverage bitmap, one write and one registered read port
// ----------------------------------------------------------------------------
module rcs_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 64
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data
);
    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

// ----- hdl/rcs_seq.sv -----
// ----------------------------------------------------------------------------
// rcs_seq
// clearing pass and word walk with read-modify-write of the bitmap
// ----------------------------------------------------------------------------
module rcs_seq #(
    parameter int DOMAIN_POINTS = 4096,
    parameter int WORD_BITS     = 64,
    parameter int NUM_WORDS     = 64,
    parameter int AW            = 6
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  rcs_pkg::t_item       i_item,
    output logic                 o_idle,
    output logic                 o_res_valid,
    output rcs_pkg::t_res        o_res,
    input  logic                 i_res_take,
    output logic                 o_rd_en,
    output logic [AW-1:0]        o_rd_addr,
    input  logic [WORD_BITS-1:0] i_rd_data,
    output logic                 o_wr_en,
    output logic [AW-1:0]        o_wr_addr,
    output logic [WORD_BITS-1:0] o_wr_data
);
    import rcs_pkg::*;

    localparam int  CLAMP    = (DOMAIN_POINTS > 8191) ? 8191 : DOMAIN_POINTS;
    localparam t_pt CLAMP_PT = CLAMP[PT_W-1:0];
    localparam t_pt WB       = WORD_BITS[PT_W-1:0];
    localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_WORDS - 1);

    localparam logic [2:0] ST_CLR   = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_RUN   = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]           r_state;
    logic [AW-1:0]        r_addr;
    logic [AW-1:0]        r_waddr;
    t_pt                  r_base;
    t_cmd                 r_cmd;
    t_pt                  r_start;
    t_pt                  r_end;
    logic                 r_err;
    logic                 r_all;
    logic                 r_pend;
    logic [WORD_BITS-1:0] r_mask;

    t_pt                  n_base;
    t_pt                  in_end;
    logic                 in_err;
    logic [WORD_BITS-1:0] mask;
    t_pt                  pt;

    // clamp the end to the domain
    always_comb begin
        in_end = ({1'b0, i_item.range_end} > CLAMP_PT) ? CLAMP_PT : {1'b0, i_item.range_end};
        in_err = {2'b00, i_item.range_start} >= in_end;
    end

    // bits of the current word that fall inside the range
    always_comb begin
        for (int i = 0; i < WORD_BITS; i++) begin
            pt      = r_base + t_pt'(i);
            mask[i] = (pt >= r_start) && (pt < r_end);
        end
    end

    assign n_base = r_base + WB;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
            r_addr  <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_pend <= (r_state == ST_RUN);
            unique case (r_state)
                ST_CLR: begin
                    if (r_addr == LAST_ADDR) begin
                        r_addr  <= '0;
                        r_state <= ST_IDLE;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                ST_IDLE: begin
                    if (i_start) begin
                        r_addr <= '0;
                        if (in_err || i_item.cmd == CMD_NONE) begin
                            r_state <= ST_DONE;
                        end else begin
                            r_state <= ST_RUN;
                        end
                    end
                end
                ST_RUN: begin
                    r_addr <= r_addr + 1'b1;
                    if (n_base >= r_end) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (i_res_take) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_CLR;
                end
            endcase
        end
    end

    // item registers and walk datapath
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_start) begin
            r_cmd   <= i_item.cmd;
            r_start <= {2'b00, i_item.range_start};
            r_end   <= in_end;
            r_err   <= in_err && (i_item.cmd != CMD_NONE);
            r_all   <= !in_err;
            r_base  <= '0;
        end else begin
            if (r_state == ST_RUN) begin
                r_base  <= n_base;
                r_mask  <= mask;
                r_waddr <= r_addr;
            end
            if (r_pend && r_cmd == CMD_QUERY && (i_rd_data & r_mask) != r_mask) begin
                r_all <= 1'b0;
            end
        end
    end

    always_comb begin
        o_rd_en   = (r_state == ST_RUN);
        o_rd_addr = r_addr;
        o_wr_en   = 1'b0;
        o_wr_addr = r_waddr;
        o_wr_data = i_rd_data;
        if (r_state == ST_CLR) begin
            o_wr_en   = 1'b1;
            o_wr_addr = r_addr;
            o_wr_data = '0;
        end else if (r_pend) begin
            case (r_cmd)
                CMD_ADD: begin
                    o_wr_en   = 1'b1;
                    o_wr_data = i_rd_data | r_mask;
                end
                CMD_REMOVE: begin
                    o_wr_en   = 1'b1;
                    o_wr_data = i_rd_data & ~r_mask;
                end
                default: begin
                    o_wr_en = 1'b0;
                end
            endcase
        end
    end

    assign o_idle            = (r_state == ST_IDLE);
    assign o_res_valid       = (r_state == ST_DONE);
    assign o_res.covered     = (r_cmd == CMD_QUERY) && r_all;
    assign o_res.range_error = r_err;
endmodule

// ----- hdl/rcs_checker.sv -----
// ----------------------------------------------------------------------------
// rcs_checker
// port-level checks of the range coverage set
// ----------------------------------------------------------------------------
module rcs_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_out_covered,
    input logic i_out_range_error
);
    // result word held while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_out_covered) && $stable(i_out_range_error))
        else $error("result word changed while stalled");

    // an empty range never reports coverage
    a_err_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_out_covered && i_out_range_error))
        else $error("covered and range error both set");

    // one command in flight
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("command taken while another is in flight");
endmodule

bind range_coverage_set rcs_checker u_rcs_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in.valid),
    .i_in_ready        (i_in.ready),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_out_covered     (o_out.covered),
    .i_out_range_error (o_out.range_error)
);

// ----- tb/tb_range_coverage_set.sv -----
// ----------------------------------------------------------------------------
// tb_range_coverage_set
// self-checking bench for the range coverage set
// ----------------------------------------------------------------------------
// drives add, remove and query commands over half-open ranges, keeps its own
// bitmap of covered points to predict each result word, and compares every
// result word field by field in arrival order. directed tests cover the
// domain edges, empty ranges, the unknown command and word boundaries. a
// long random run follows, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_range_coverage_set;
    import rcs_pkg::*;

    localparam int DOMAIN = 4096;
    localparam int WBITS  = 64;
    localparam int N_RANDOM = 1850;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rcs_in_if  in_if ();
    rcs_out_if out_if ();

    range_coverage_set #(
        .DOMAIN_POINTS(DOMAIN),
        .WORD_BITS    (WBITS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    always #1 i_clk = ~i_clk;

    bit   cov_map [0:DOMAIN-1];
    t_res pending_res [$];
    int   recent_lo [$];
    int   recent_hi [$];
    bit   idle_on = 1'b1;
    int   n_fail = 0;

    function automatic t_res apply_range_cmd(t_cmd c, t_start s, t_end e);
        t_res r;
        int   lo;
        int   hi;
        bit   all;
        r  = '0;
        lo = s;
        hi = (e > DOMAIN) ? DOMAIN : e;
        if (c == CMD_NONE)
            return r;
        if (lo >= hi) begin
            r.range_error = 1'b1;
            return r;
        end
        all = 1'b1;
        for (int p = lo; p < hi; p++) begin
            case (c)
                CMD_ADD:    cov_map[p] = 1'b1;
                CMD_REMOVE: cov_map[p] = 1'b0;
                default: begin
                    if (!cov_map[p])
                        all = 1'b0;
                end
            endcase
        end
        if (c == CMD_QUERY)
            r.covered = all;
        return r;
    endfunction

    task automatic send_word(t_cmd c, int s, int e);
        int gap;
        gap = idle_on ? $urandom_range(0, 12) : 0;
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.cmd         <= c;
        in_if.range_start <= t_start'(s);
        in_if.range_end   <= t_end'(e);
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        pending_res.push_back(apply_range_cmd(c, t_start'(s), t_end'(e)));
    endtask

    task automatic test_cleared_map();
        send_word(CMD_QUERY, 0, DOMAIN);
        send_word(CMD_QUERY, 0, 1);
    endtask

    task automatic test_domain_edges();
        send_word(CMD_ADD, 0, DOMAIN);
        send_word(CMD_QUERY, 0, DOMAIN);
        send_word(CMD_QUERY, 0, 8191);
        send_word(CMD_QUERY, 4095, DOMAIN);
        send_word(CMD_REMOVE, 0, 1);
        send_word(CMD_QUERY, 0, DOMAIN);
        send_word(CMD_QUERY, 1, 8191);
        send_word(CMD_REMOVE, 4095, 8191);
        send_word(CMD_QUERY, 4094, 4095);
        send_word(CMD_QUERY, 4094, DOMAIN);
    endtask

    task automatic test_empty_and_unknown();
        send_word(CMD_ADD, 5, 5);
        send_word(CMD_QUERY, 100, 0);
        send_word(CMD_REMOVE, 4095, 4095);
        send_word(CMD_ADD, 4095, 0);
        send_word(CMD_NONE, 10, 200);
        send_word(CMD_NONE, 300, 2);
    endtask

    task automatic test_word_boundaries();
        send_word(CMD_REMOVE, 0, DOMAIN);
        send_word(CMD_ADD, 63, 65);
        send_word(CMD_QUERY, 63, 65);
        send_word(CMD_QUERY, 62, 65);
        send_word(CMD_QUERY, 64, 66);
    endtask

    task automatic test_random_ranges();
        int   pick;
        int   s;
        int   e;
        int   len;
        int   k;
        t_cmd c;
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 100 == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
                c = t_cmd'($urandom_range(0, 3));
                s = $urandom & 12'hfff;
                e = $urandom & 13'h1fff;
            end else if (pick < 10) begin
                c = t_cmd'($urandom_range(0, 2));
                s = $urandom_range(0, DOMAIN - 1);
                e = $urandom_range(0, s);
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 40)
                    c = CMD_ADD;
                else if (pick < 60)
                    c = CMD_REMOVE;
                else
                    c = CMD_QUERY;
                if (c == CMD_QUERY && recent_lo.size() > 0 && $urandom_range(0, 1)) begin
                    k = $urandom_range(0, recent_lo.size() - 1);
                    s = $urandom_range(recent_lo[k], recent_hi[k] - 1);
                    e = $urandom_range(s + 1, recent_hi[k]);
                end else begin
                    s = $urandom_range(0, DOMAIN - 1);
                    len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, DOMAIN)
                                                       : $urandom_range(1, 150);
                    e = s + len;
                    if ($urandom_range(0, 19) == 0)
                        e = $urandom_range(s + 1, 8191);
                end
                if (c == CMD_ADD) begin
                    recent_lo.push_back(s);
                    recent_hi.push_back((e > DOMAIN) ? DOMAIN : e);
                    if (recent_lo.size() > 8) begin
                        recent_lo.delete(0);
                        recent_hi.delete(0);
                    end
                end
            end
            send_word(c, s, e);
        end
    endtask

    // result channel: random stalls, then compare with the oldest prediction
    initial begin
        int   stall;
        t_res want;
        forever begin
            stall = idle_on ? $urandom_range(0, 12) : 0;
            if (stall > 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!(out_if.valid && out_if.ready)) @(posedge i_clk);
            if (pending_res.size() == 0) begin
                $error("unexpected result word: covered %0b range_error %0b",
                       out_if.covered, out_if.range_error);
                n_fail++;
            end else begin
                want = pending_res.pop_front();
                if (out_if.covered !== want.covered) begin
                    $error("covered: expected %0b, got %0b", want.covered, out_if.covered);
                    n_fail++;
                end
                if (out_if.range_error !== want.range_error) begin
                    $error("range_error: expected %0b, got %0b",
                           want.range_error, out_if.range_error);
                    n_fail++;
                end
            end
        end
    end

    initial begin
        i_rst_n           <= 1'b0;
        in_if.valid       <= 1'b0;
        in_if.cmd         <= CMD_ADD;
        in_if.range_start <= '0;
        in_if.range_end   <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_cleared_map();
        test_domain_edges();
        test_empty_and_unknown();
        test_word_boundaries();
        test_random_ranges();
        in_if.valid <= 1'b0;

        while (pending_res.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        if (n_fail == 0 && pending_res.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #1500000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/rcs_pkg.sv
hdl/rcs_in_if.sv
hdl/rcs_out_if.sv
hdl/rcs_mem.sv
hdl/rcs_seq.sv
hdl/range_coverage_set.sv
hdl/rcs_checker.sv
tb/tb_range_coverage_set.sv
